### src/ulbp_pkg.sv
package ulbp_pkg;

	localparam int PIX_W = 8;
	localparam int COORD_W = 10;
	localparam int BIN_W = 4;
	localparam int SIZE_W = 11;
	localparam int MAX_HEIGHT = 1024;
	localparam logic [BIN_W-1:0] BIN_NONUNIFORM = 4'd9;

	// Fractional parts of 0.70710678 * r for r = 1..3, in Q0.20.
	localparam logic [19:0] FRAC_Q20 [3] = '{20'd741455, 20'd434334, 20'd127214};

	typedef logic [PIX_W-1:0] pix_t;

	// Register indexes on the configuration port.
	typedef enum logic [1:0] {
		REG_RADIUS = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2,
		REG_NONE   = 2'd3
	} reg_idx_t;

	// Position information that travels with a word down the pipeline.
	typedef struct packed {
		logic               emit;
		logic               last;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
	} ulbp_tag_t;

endpackage

### src/ulbp_ram.sv
module ulbp_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port; the read data holds while re is low.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/ulbp_window.sv
module ulbp_window #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_RADIUS = 3
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  ulbp_pkg::pix_t               in_pixel,
	input  logic [$clog2(MAX_WIDTH)-1:0] in_col,
	input  ulbp_pkg::ulbp_tag_t          in_tag,
	output logic                         out_valid,
	output ulbp_pkg::ulbp_tag_t          out_tag,
	output ulbp_pkg::pix_t               win [2*MAX_RADIUS+1][2*MAX_RADIUS+1]
);

	import ulbp_pkg::*;

	localparam int WIN = 2*MAX_RADIUS+1;
	localparam int LS = 2*MAX_RADIUS;
	localparam int CW = $clog2(MAX_WIDTH);

	logic            v_s1;
	pix_t            pix_s1;
	logic [CW-1:0]   col_s1;
	ulbp_tag_t       tag_s1;
	logic [LS*8-1:0] rdata;
	logic [LS*8-1:0] wdata;
	logic            we;
	pix_t            colv [WIN];
	pix_t            win_q [WIN][WIN];
	logic            v_s2;
	ulbp_tag_t       tag_s2;

	// Each column entry holds the last LS rows of that column, newest first.
	ulbp_ram #(.WIDTH(LS*8), .DEPTH(MAX_WIDTH)) u_lines (
		.clk   (clk),
		.we    (we),
		.waddr (col_s1),
		.wdata (wdata),
		.re    (en),
		.raddr (in_col),
		.rdata (rdata)
	);

	// Stage 1 holds the word while the column is read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1 <= in_pixel;
			col_s1 <= in_col;
			tag_s1 <= in_tag;
		end
	end

	// The full column: the new pixel on top of the stored rows.
	always_comb begin
		colv[0] = pix_s1;
		for (int i = 1; i < WIN; i++) begin
			colv[i] = rdata[(i-1)*8 +: 8];
		end
	end

	// Write back the column shifted down by one row.
	assign wdata = {rdata[(LS-1)*8-1:0], pix_s1};
	assign we = en && v_s1;

	// The window shifts in one new column for every pixel.
	always_ff @(posedge clk) begin
		if (en && v_s1) begin
			win_q[0] <= colv;
			for (int j = 1; j < WIN; j++) begin
				win_q[j] <= win_q[j-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1 && tag_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s2 <= tag_s1;
		end
	end

	assign out_valid = v_s2;
	assign out_tag = tag_s2;
	assign win = win_q;

	// A write back never lands on the column being read in the same cycle.
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		we && in_valid |-> col_s1 != in_col)
		else $error("line store read and write hit the same column");

endmodule

### src/ulbp_core.sv
module ulbp_core #(
	parameter int MAX_RADIUS = 3,
	parameter int FRAC_BITS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic [1:0]                 radius,
	input  logic                       in_valid,
	input  ulbp_pkg::ulbp_tag_t        in_tag,
	input  ulbp_pkg::pix_t             win [2*MAX_RADIUS+1][2*MAX_RADIUS+1],
	output logic                       out_valid,
	output logic [ulbp_pkg::BIN_W-1:0] out_bin,
	output ulbp_pkg::ulbp_tag_t        out_tag
);

	import ulbp_pkg::*;

	localparam int WW = 2*FRAC_BITS+1;
	localparam int PW = PIX_W+WW;
	localparam int SW = PW+2;
	localparam int SX [4] = '{1, -1, -1, 1};
	localparam int SY [4] = '{-1, -1, 1, 1};

	function automatic int wo_of(input int r);
		return int'((FRAC_Q20[r-1] + (20'd1 << (19-FRAC_BITS))) >> (20-FRAC_BITS));
	endfunction

	function automatic logic [BIN_W-1:0] to_bin(input logic [7:0] code);
		logic [7:0] diff;
		logic [3:0] trans;
		logic [3:0] ones;
		diff = code ^ {code[0], code[7:1]};
		trans = '0;
		ones = '0;
		for (int i = 0; i < 8; i++) begin
			trans = trans + 4'(diff[i]);
			ones = ones + 4'(code[i]);
		end
		return (trans <= 4'd2) ? ones : BIN_NONUNIFORM;
	endfunction

	pix_t          ctr_c;
	pix_t          dpix_c [4][4];
	logic [3:0]    axis_c;
	pix_t          ctr_s3;
	pix_t          dpix_s3 [4][4];
	logic [3:0]    axis_s3;
	logic          v_s3;
	ulbp_tag_t     tag_s3;
	logic [WW-1:0] wii, wio, woo;
	logic [PW-1:0] prod_s4 [4][4];
	pix_t          ctr_s4;
	logic [3:0]    axis_s4;
	logic          v_s4;
	ulbp_tag_t     tag_s4;
	logic [SW-1:0] sum [4];
	logic [SW-1:0] ref_val;
	logic [7:0]    code;
	logic          valid_q;
	logic [BIN_W-1:0] bin_q;
	ulbp_tag_t     tag_q;

	// Pick the taps of the circle for the configured radius and compare the axis ones.
	always_comb begin
		int k;
		int xi, xo, yi, yo;
		k = 0;
		xi = 0;
		xo = 0;
		yi = 0;
		yo = 0;
		ctr_c = '0;
		axis_c = '0;
		for (int d = 0; d < 4; d++) begin
			for (int j = 0; j < 4; j++) begin
				dpix_c[d][j] = '0;
			end
		end
		for (int rr = 1; rr <= MAX_RADIUS; rr++) begin
			if (radius == 2'(rr)) begin
				k = rr-1;
				ctr_c = win[rr][rr];
				axis_c[0] = win[0][rr] >= win[rr][rr];
				axis_c[1] = win[rr][2*rr] >= win[rr][rr];
				axis_c[2] = win[2*rr][rr] >= win[rr][rr];
				axis_c[3] = win[rr][0] >= win[rr][rr];
				for (int d = 0; d < 4; d++) begin
					xi = SX[d]*k;
					xo = SX[d]*(k+1);
					yi = SY[d]*k;
					yo = SY[d]*(k+1);
					dpix_c[d][0] = win[rr-xi][rr-yi];
					dpix_c[d][1] = win[rr-xo][rr-yi];
					dpix_c[d][2] = win[rr-xi][rr-yo];
					dpix_c[d][3] = win[rr-xo][rr-yo];
				end
			end
		end
	end

	// Bilinear weights for the configured radius.
	always_comb begin
		int wo, wi;
		wo = 0;
		wi = 0;
		wii = '0;
		wio = '0;
		woo = '0;
		for (int rr = 1; rr <= MAX_RADIUS; rr++) begin
			if (radius == 2'(rr)) begin
				wo = wo_of(rr);
				wi = (1 << FRAC_BITS) - wo;
				wii = WW'(wi*wi);
				wio = WW'(wi*wo);
				woo = WW'(wo*wo);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			valid_q <= 1'b0;
		end else if (en) begin
			v_s3 <= in_valid;
			v_s4 <= v_s3;
			valid_q <= v_s4;
		end
	end

	// Stage 3 registers the taps, stage 4 the weighted products.
	always_ff @(posedge clk) begin
		if (en) begin
			ctr_s3 <= ctr_c;
			dpix_s3 <= dpix_c;
			axis_s3 <= axis_c;
			tag_s3 <= in_tag;
			for (int d = 0; d < 4; d++) begin
				prod_s4[d][0] <= PW'(dpix_s3[d][0]) * PW'(wii);
				prod_s4[d][1] <= PW'(dpix_s3[d][1]) * PW'(wio);
				prod_s4[d][2] <= PW'(dpix_s3[d][2]) * PW'(wio);
				prod_s4[d][3] <= PW'(dpix_s3[d][3]) * PW'(woo);
			end
			ctr_s4 <= ctr_s3;
			axis_s4 <= axis_s3;
			tag_s4 <= tag_s3;
		end
	end

	// Sum each diagonal exactly, compare against the scaled centre, form the code.
	always_comb begin
		ref_val = SW'(ctr_s4) << (2*FRAC_BITS);
		for (int d = 0; d < 4; d++) begin
			sum[d] = SW'(prod_s4[d][0]) + SW'(prod_s4[d][1])
				+ SW'(prod_s4[d][2]) + SW'(prod_s4[d][3]);
		end
		for (int d = 0; d < 4; d++) begin
			code[2*d] = axis_s4[d];
			code[2*d+1] = sum[d] >= ref_val;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bin_q <= to_bin(code);
			tag_q <= tag_s4;
		end
	end

	assign out_valid = valid_q;
	assign out_bin = bin_q;
	assign out_tag = tag_q;

endmodule

### src/uniform_lbp_code_stream.sv
// The code of the pixel that completes a window passes through the line store read, the
// window shift, the tap, product and output registers before it is presented on the
// output. Throughput: one pixel per cycle while the output is not stalled; the column
// read-modify-write in the line store and the window shift overlap across pixels. Reset
// clears counters, valid flags and registers to radius 1, 640 x 480. The line store is
// not cleared; rows are always rewritten before a code uses them.
module uniform_lbp_code_stream #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_RADIUS = 3,
	parameter int FRAC_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] pixel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [3:0] lbp_bin, [13:4] center_row, [23:14] center_col
	output logic        m_tlast    // last_of_frame
);

	import ulbp_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int MIN_SIZE = 2*MAX_RADIUS+1;
	localparam int WIN = 2*MAX_RADIUS+1;

	logic [1:0]        radius_q;
	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;
	logic [CW-1:0]     col_q;
	logic [COORD_W-1:0] row_q;
	logic [1:0]        r_eff;
	logic [CW:0]       w_eff;
	logic [SIZE_W-1:0] h_eff;
	logic              cfg_wr;
	logic              en;
	logic              accept;
	logic              col_end;
	logic              row_end;
	ulbp_tag_t         in_tag;
	logic              w_valid;
	ulbp_tag_t         w_tag;
	pix_t              win [WIN][WIN];
	logic              c_valid;
	logic [BIN_W-1:0]  c_bin;
	ulbp_tag_t         c_tag;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 2'd1;
			width_q <= 11'd640;
			height_q <= 11'd480;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_RADIUS: radius_q <= pwdata[1:0];
				REG_WIDTH:  width_q <= pwdata[SIZE_W-1:0];
				REG_HEIGHT: height_q <= pwdata[SIZE_W-1:0];
				REG_NONE:   ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_RADIUS: prdata = {30'd0, radius_q};
			REG_WIDTH:  prdata = {21'd0, width_q};
			REG_HEIGHT: prdata = {21'd0, height_q};
			REG_NONE:   prdata = '0;
		endcase
	end

	// Effective settings, saturated to the supported ranges.
	always_comb begin
		if (radius_q == 2'd0) begin
			r_eff = 2'd1;
		end else if (32'(radius_q) > MAX_RADIUS) begin
			r_eff = 2'(MAX_RADIUS);
		end else begin
			r_eff = radius_q;
		end
		if (32'(width_q) < MIN_SIZE) begin
			w_eff = (CW+1)'(MIN_SIZE);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = (CW+1)'(MAX_WIDTH);
		end else begin
			w_eff = (CW+1)'(width_q);
		end
		if (32'(height_q) < MIN_SIZE) begin
			h_eff = SIZE_W'(MIN_SIZE);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			h_eff = SIZE_W'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
	end

	// The whole pipeline moves whenever the output register can take a word.
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;
	assign accept = s_tvalid && s_tready;

	assign col_end = {1'b0, col_q} == w_eff - 1'b1;
	assign row_end = {1'b0, row_q} == h_eff - 1'b1;

	// Position of the centre and whether this pixel completes a window.
	always_comb begin
		in_tag.emit = ({1'b0, row_q} >= {8'd0, r_eff, 1'b0})
			&& (32'(col_q) >= 32'({r_eff, 1'b0}));
		in_tag.last = row_end && col_end;
		in_tag.row = row_q - COORD_W'(r_eff);
		in_tag.col = COORD_W'(col_q - CW'(r_eff));
	end

	// Raster counters; a write to the radius, width or height register restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr && paddr[3:2] != REG_NONE) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	ulbp_window #(.MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS)) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (accept),
		.in_pixel  (s_tdata),
		.in_col    (col_q),
		.in_tag    (in_tag),
		.out_valid (w_valid),
		.out_tag   (w_tag),
		.win       (win)
	);

	ulbp_core #(.MAX_RADIUS(MAX_RADIUS), .FRAC_BITS(FRAC_BITS)) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.radius    (r_eff),
		.in_valid  (w_valid),
		.in_tag    (w_tag),
		.win       (win),
		.out_valid (c_valid),
		.out_bin   (c_bin),
		.out_tag   (c_tag)
	);

	assign m_tvalid = c_valid;
	assign m_tdata = {c_tag.col, c_tag.row, c_bin};
	assign m_tlast = c_tag.last;

	a_bin_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[3:0] <= BIN_NONUNIFORM)
		else $error("code bin out of range");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, col_q} < w_eff)
		else $error("column counter beyond row width");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, row_q} < h_eff)
		else $error("row counter beyond frame height");

endmodule

### verif/tb_uniform_lbp_code_stream.sv
`timescale 1ns / 100ps

module tb_uniform_lbp_code_stream;
	import ulbp_pkg::*;

	localparam int RING = 7;
	localparam int LINE = 1024;
	localparam int LIMIT = 400000;

	// Code result as it leaves the block.
	typedef struct packed {
		logic [3:0]  bin;
		logic [9:0]  row;
		logic [9:0]  col;
		logic        last;
	} lbp_code_t;

	// Scoreboard: tracks the frame position and window contents, predicts codes.
	class lbp_scoreboard;
		pix_t        lines [RING][LINE];
		int unsigned row_pos, col_pos;
		logic [1:0]  radius_reg;
		logic [10:0] width_reg, height_reg;
		lbp_code_t   pending_codes [$];
		int          mismatches;

		function new();
			radius_reg = 2'd1;
			width_reg = 11'd640;
			height_reg = 11'd480;
			row_pos = 0;
			col_pos = 0;
			mismatches = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [31:0] value);
			case (idx)
				REG_RADIUS: begin
					radius_reg = value[1:0];
				end
				REG_WIDTH: begin
					width_reg = value[10:0];
				end
				REG_HEIGHT: begin
					height_reg = value[10:0];
				end
				default: begin
					return;
				end
			endcase
			row_pos = 0;
			col_pos = 0;
		endfunction

		function longint unsigned pel(int unsigned r, int unsigned c);
			return lines[r % RING][c % LINE];
		endfunction

		// Uniform patterns map to their popcount, all others to the non-uniform bin.
		function logic [3:0] code_bin(logic [7:0] code);
			logic [7:0] diff;
			diff = code ^ {code[0], code[7:1]};
			return ($countones(diff) <= 2) ? 4'($countones(code)) : BIN_NONUNIFORM;
		endfunction

		function void note_pixel(pix_t value);
			int unsigned r, w, h, cr, cc, k, xi, xo, yi, yo;
			longint unsigned wo, wi, ctr, thresh, sum;
			logic [7:0] code;
			lbp_code_t res;
			r = (radius_reg == 0) ? 1 : radius_reg;
			w = (width_reg < 7) ? 7 : (width_reg > 1024) ? 1024 : width_reg;
			h = (height_reg < 7) ? 7 : (height_reg > 1024) ? 1024 : height_reg;
			lines[row_pos % RING][col_pos % LINE] = value;
			if (row_pos >= 2 * r && col_pos >= 2 * r) begin
				cr = row_pos - r;
				cc = col_pos - r;
				wo = (FRAC_Q20[r-1] + (1 << 11)) >> 12;
				wi = 256 - wo;
				ctr = pel(cr, cc);
				thresh = ctr * 65536;
				k = r - 1;
				code = '0;
				code[0] = pel(cr, cc + r) >= ctr;
				code[2] = pel(cr - r, cc) >= ctr;
				code[4] = pel(cr, cc - r) >= ctr;
				code[6] = pel(cr + r, cc) >= ctr;
				// Diagonals, counterclockwise from upper right.
				for (int d = 0; d < 4; d++) begin
					xi = (d == 0 || d == 3) ? cc + k : cc - k;
					xo = (d == 0 || d == 3) ? cc + k + 1 : cc - k - 1;
					yi = (d >= 2) ? cr + k : cr - k;
					yo = (d >= 2) ? cr + k + 1 : cr - k - 1;
					sum = pel(yi, xi) * wi * wi + pel(yi, xo) * wo * wi
						+ pel(yo, xi) * wi * wo + pel(yo, xo) * wo * wo;
					code[2 * d + 1] = sum >= thresh;
				end
				res.bin = code_bin(code);
				res.row = cr[9:0];
				res.col = cc[9:0];
				res.last = (row_pos == h - 1 && col_pos == w - 1);
				pending_codes.push_back(res);
			end
			col_pos++;
			if (col_pos >= w) begin
				col_pos = 0;
				row_pos++;
				if (row_pos >= h) begin
					row_pos = 0;
				end
			end
		endfunction

		function void check_code(lbp_code_t got);
			lbp_code_t want;
			if (pending_codes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected code: bin %0d row %0d col %0d last %0b",
						got.bin, got.row, got.col, got.last);
				end
				return;
			end
			want = pending_codes.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display({"code mismatch: expected bin %0d row %0d col %0d last %0b,",
						" got bin %0d row %0d col %0d last %0b"},
						want.bin, want.row, want.col, want.last,
						got.bin, got.row, got.col, got.last);
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	logic        s_tvalid, s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid, m_tready;
	logic [23:0] m_tdata;
	logic        m_tlast;

	lbp_scoreboard sb;
	bit          calm;
	bit          source_done;
	int unsigned cycles;
	int          pattern;

	uniform_lbp_code_stream DUT (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Receiver with random stall bursts; checks each accepted word.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_code('{m_tdata[3:0], m_tdata[13:4], m_tdata[23:14], m_tlast});
		end
	end

	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				gap = $urandom_range(1, 5);
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	// Cycle limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("uniform_lbp_code_stream regression: fail");
			$finish;
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		sb.write_reg(idx, value);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Pixels: random, black or white, or flat or ramp texture for uniform codes.
	function automatic pix_t pick_pixel(int n);
		case (pattern)
			0: return pix_t'($urandom);
			1: return pix_t'($urandom_range(0, 1) ? 8'd128 : 8'd127);
			2: return pix_t'(n * 7);
			default: return ($urandom_range(0, 1) ? 8'hFF : 8'h00);
		endcase
	endfunction

	task automatic send_pixel(pix_t value);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= value;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		sb.note_pixel(value);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending_codes.size() != 0) begin
			@(posedge clk);
		end
		repeat (12) @(posedge clk);
	endtask

	task automatic run_frame(logic [1:0] rad, logic [10:0] w, logic [10:0] h, int npix);
		write_reg(REG_RADIUS, {30'd0, rad});
		write_reg(REG_WIDTH, {21'd0, w});
		write_reg(REG_HEIGHT, {21'd0, h});
		pattern = $urandom_range(0, 3);
		for (int i = 0; i < npix; i++) begin
			send_pixel(pick_pixel(i));
		end
		drain();
	endtask

	initial begin
		int total;
		sb = new();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		calm = 1'b0;
		cycles = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes of pixel values at radius 1 on a minimal frame.
		write_reg(REG_NONE, 32'hFFFF_FFFF);
		write_reg(REG_WIDTH, 32'd7);
		write_reg(REG_HEIGHT, 32'd7);
		for (int i = 0; i < 25; i++) begin
			send_pixel((i % 3 == 0) ? 8'hFF : (i % 3 == 1) ? 8'h00 : 8'h80);
		end
		drain();

		// Edge cases: radius 0, sizes out of range, radius 3 at 7x7 and 1024x1024.
		run_frame(2'd0, 11'd3, 11'd0, 49);
		run_frame(2'd3, 11'd7, 11'd7, 49);
		run_frame(2'd2, 11'd2047, 11'd7, 40);
		run_frame(2'd3, 11'd1024, 11'd1024, 30);

		// Random frames, mostly small and complete.
		total = 0;
		while (total < 1050) begin
			int w, h, n;
			w = $urandom_range(7, 14);
			h = $urandom_range(7, 10);
			n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, w * h) : w * h;
			if (total > 850) begin
				calm = 1'b1;
			end
			run_frame(2'($urandom_range(0, 3)), 11'(w), 11'(h), n);
			total += n;
		end
		// Frame that continues into the next one without reconfiguration.
		run_frame(2'd1, 11'd8, 11'd7, 80);

		if (sb.mismatches == 0 && sb.pending_codes.size() == 0) begin
			$display("uniform_lbp_code_stream regression: pass");
		end else begin
			$display("uniform_lbp_code_stream regression: fail");
		end
		$finish;
	end

endmodule

### filelist.f
src/ulbp_pkg.sv
src/ulbp_ram.sv
src/ulbp_window.sv
src/ulbp_core.sv
src/uniform_lbp_code_stream.sv
verif/tb_uniform_lbp_code_stream.sv
